/* design/vts_pkg.sv */
// Shared constants for the version tag scanner.
package vts_pkg;

    localparam int CHAR_WIDTH          = 16;
    localparam int FIELD_WIDTH         = 16;
    localparam int SEGMENT_WIDTH_DFLT  = 16;
    localparam int COUNT_WIDTH         = 3;

    localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 16'h0000;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_V = 16'h0076;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_V = 16'h0056;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DOT     = 16'h002E;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 16'h0030;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 16'h0039;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = 3'd4;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TWO   = 3'd2;
    localparam logic [COUNT_WIDTH-1:0] COUNT_THREE = 3'd3;

endpackage

/* design/version_tag_scanner_core.sv */
// Version tag scanner: finds the first v<major>.<minor>[.<patch>] tag in a character stream.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, char_code, last_char | to block
//   out     | out_valid, out_ready, version_found,     | from block
//           | major, minor, patch                      |
//
// One character is taken every cycle while in_ready is high; the scan step is a single
// pass of compare, multiply-by-ten and saturate logic in front of the state register.
// A transfer with last_char set yields one result in the output register on the next cycle.
// in_ready drops only while a result waits in the output register and out_ready is low.
// Reset clears the scan state and empties the output register.
module version_tag_scanner_core
#(
    parameter int SEGMENT_WIDTH = vts_pkg::SEGMENT_WIDTH_DFLT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [vts_pkg::CHAR_WIDTH-1:0]    char_code,
    input  logic                              last_char,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              version_found,
    output logic [vts_pkg::FIELD_WIDTH-1:0]   major,
    output logic [vts_pkg::FIELD_WIDTH-1:0]   minor,
    output logic [vts_pkg::FIELD_WIDTH-1:0]   patch
);
    import vts_pkg::*;

    localparam int SW = SEGMENT_WIDTH;
    localparam logic [SW-1:0] SEG_MAX = '1;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_NEED_DIGIT,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [COUNT_WIDTH-1:0] seg_cnt;
        logic [SW-1:0]          digit;
        logic [SW-1:0]          seg0;
        logic [SW-1:0]          seg1;
        logic [SW-1:0]          seg2;
        logic                   matched;
        logic                   ended;
    } scan_t;

    localparam scan_t SCAN_RESET = '{
        phase:   PH_SEARCH,
        seg_cnt: '0,
        digit:   '0,
        seg0:    '0,
        seg1:    '0,
        seg2:    '0,
        matched: 1'b0,
        ended:   1'b0
    };

    function automatic scan_t store_seg(scan_t s);
        scan_t r;
        r = s;
        if (s.seg_cnt == 3'd0)
        begin
            r.seg0 = s.digit;
        end
        else if (s.seg_cnt == 3'd1)
        begin
            r.seg1 = s.digit;
        end
        else if (s.seg_cnt == COUNT_TWO)
        begin
            r.seg2 = s.digit;
        end
        if (s.seg_cnt < COUNT_MAX)
        begin
            r.seg_cnt = s.seg_cnt + 3'd1;
        end
        r.digit = '0;
        return r;
    endfunction

    function automatic scan_t take_char(scan_t s, logic [CHAR_WIDTH-1:0] c);
        scan_t          r;
        logic           is_digit;
        logic           search;
        logic [SW-1:0]  dval;
        logic [SW+3:0]  ext;
        logic [SW+3:0]  prod;
        r        = s;
        search   = 1'b0;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        dval     = {{(SW-4){1'b0}}, c[3:0]};
        ext      = {4'b0000, s.digit};
        prod     = (ext << 3) + (ext << 1) + {{SW{1'b0}}, c[3:0]};
        if (!(s.matched || s.ended))
        begin
            case (s.phase)
                PH_NEED_DIGIT:
                begin
                    if (is_digit)
                    begin
                        r.digit = dval;
                        r.phase = PH_DIGITS;
                    end
                    else
                    begin
                        r.phase = PH_SEARCH;
                        search  = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        r.digit = (prod > {4'b0000, SEG_MAX}) ? SEG_MAX : prod[SW-1:0];
                    end
                    else if (c == CHAR_DOT)
                    begin
                        r       = store_seg(s);
                        r.phase = PH_NEED_DIGIT;
                    end
                    else
                    begin
                        r       = store_seg(s);
                        r.phase = PH_SEARCH;
                        if (r.seg_cnt == COUNT_TWO || r.seg_cnt == COUNT_THREE)
                        begin
                            if (r.seg_cnt == COUNT_TWO)
                            begin
                                r.seg2 = '0;
                            end
                            r.matched = 1'b1;
                        end
                        else
                        begin
                            search = 1'b1;
                        end
                    end
                end
                default:
                begin
                    r.phase = PH_SEARCH;
                    search  = 1'b1;
                end
            endcase
            if (search)
            begin
                if (c == CHAR_NUL)
                begin
                    r.ended = 1'b1;
                end
                else if (c == CHAR_LOWER_V || c == CHAR_UPPER_V)
                begin
                    r.phase   = PH_NEED_DIGIT;
                    r.seg_cnt = '0;
                    r.digit   = '0;
                    r.seg0    = '0;
                    r.seg1    = '0;
                    r.seg2    = '0;
                end
            end
        end
        return r;
    endfunction

    scan_t                  state_reg;
    scan_t                  step_next;
    scan_t                  term_next;
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [FIELD_WIDTH-1:0] major_reg;
    logic [FIELD_WIDTH-1:0] minor_reg;
    logic [FIELD_WIDTH-1:0] patch_reg;
    logic                   in_xfer;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign step_next = take_char(state_reg, char_code);
    assign term_next = take_char(step_next, CHAR_NUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SCAN_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            major_reg     <= '0;
            minor_reg     <= '0;
            patch_reg     <= '0;
        end
        else
        begin
            if (in_xfer && last_char)
            begin
                state_reg     <= SCAN_RESET;
                out_valid_reg <= 1'b1;
                found_reg     <= term_next.matched;
                major_reg     <= term_next.matched ? FIELD_WIDTH'(term_next.seg0) : '0;
                minor_reg     <= term_next.matched ? FIELD_WIDTH'(term_next.seg1) : '0;
                patch_reg     <= term_next.matched ? FIELD_WIDTH'(term_next.seg2) : '0;
            end
            else
            begin
                if (in_xfer)
                begin
                    state_reg <= step_next;
                end
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign version_found = found_reg;
    assign major         = major_reg;
    assign minor         = minor_reg;
    assign patch         = patch_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_char |=> out_valid_reg)
        else $error("last transfer did not load a result");

    a_last_restarts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_char |=> state_reg.phase == PH_SEARCH && !state_reg.matched
                                 && !state_reg.ended && state_reg.seg_cnt == 3'd0)
        else $error("scan state not restarted after last transfer");

    a_no_tag_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> major_reg == '0 && minor_reg == '0
                                        && patch_reg == '0)
        else $error("segments nonzero without a tag");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seg_cnt <= COUNT_MAX)
        else $error("segment count past saturation");

endmodule
